// ===== hdl/tfsjc_pkg.sv =====
// ============================================================================
// Trigger feed sequencer package
// Item formats, mode codes, switch and register codes, and fixed constants
// shared by the sequencer RTL.
// ============================================================================
`default_nettype none

package tfsjc_pkg;

  // operating modes
  typedef enum logic [2:0] {
    MODE_STOP  = 3'd0,
    MODE_PREP  = 3'd1,
    MODE_READY = 3'd2,
    MODE_SHOOT = 3'd3,
    MODE_JAM   = 3'd4
  } mode_e;

  // item opcodes
  localparam logic OP_INIT = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // shoot switch codes; anything else is off
  localparam logic [1:0] SW_WARM = 2'd1;
  localparam logic [1:0] SW_FIRE = 2'd2;

  // register map (word index)
  localparam int unsigned CFG_ADDR_W = 5;
  localparam logic [2:0] REG_FRICTION_SPEED    = 3'd0;
  localparam logic [2:0] REG_BULLET_ANGLE      = 3'd1;
  localparam logic [2:0] REG_ANGLE_TOLERANCE   = 3'd2;
  localparam logic [2:0] REG_POS_GAIN          = 3'd3;
  localparam logic [2:0] REG_MAX_TRIGGER_SPEED = 3'd4;
  localparam logic [2:0] REG_BLOCK_SPEED       = 3'd5;
  localparam logic [2:0] REG_JAM_TICKS         = 3'd6;
  localparam logic [2:0] REG_REVERSE_TICKS     = 3'd7;

  // register reset values
  localparam logic [14:0] FRICTION_SPEED_RST    = 15'd6000;
  localparam logic [19:0] BULLET_ANGLE_RST      = 20'd103680;
  localparam logic [15:0] ANGLE_TOLERANCE_RST   = 16'd3200;
  localparam logic [15:0] POS_GAIN_RST          = 16'd960;
  localparam logic [14:0] MAX_TRIGGER_SPEED_RST = 15'd10000;
  localparam logic [14:0] BLOCK_SPEED_RST       = 15'd100;
  localparam logic [15:0] JAM_TICKS_RST         = 16'd500;
  localparam logic [15:0] REVERSE_TICKS_RST     = 16'd100;

  // one turn is 23040 units of 1/64 degree
  localparam logic signed [16:0] HALF_TURN = 17'sd11520;
  localparam logic signed [16:0] FULL_TURN = 17'sd23040;

  // friction wheels count as up to speed inside this window
  localparam logic [17:0] FRICTION_WINDOW = 18'd500;

  // trigger command while clearing a jam
  localparam logic signed [15:0] JAM_TRIGGER_CMD = -16'sd300;

  // P path: error magnitude capped at 2^28 keeps the quotient at its cap
  localparam int unsigned MAG_BITS   = 29;
  localparam int unsigned GAIN_SHIFT = 12;
  localparam int unsigned PROD_BITS  = MAG_BITS + 16;
  localparam logic [16:0] PCMD_CAP   = 17'd65536;

  typedef struct packed {
    logic               op;
    logic        [1:0]  switch_pos;
    logic        [14:0] raw_angle;
    logic signed [15:0] trigger_speed;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } in_item_t;

  typedef struct packed {
    logic        [14:0] left_cmd;
    logic signed [15:0] right_cmd;
    logic signed [15:0] trigger_cmd;
    logic        [2:0]  mode;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/trigger_feed_sequencer_with_jam_clear_top.sv =====
// Path: stages A to D, with a low out_ready_i stalling them. Throughput: one word
// per cycle while not stalled; the mode/angle state closes its loop in a single
// stage, the proportional multiply and the clamp sit in stages after it.
// Reset: asynchronous, active low; mode stop, angles and timers zero, all
// registers at their default values; no clearing pass.
// ============================================================================
// Trigger feed sequencer with jam clear
// Unwraps the trigger angle, runs the stop/prepare/ready/shoot/jammed modes,
// and produces friction wheel setpoints and a clamped P trigger command.
// ============================================================================
`default_nettype none

module trigger_feed_sequencer_with_jam_clear_top #(
  parameter int unsigned ANGLE_WIDTH = 40,
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input words
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire tfsjc_pkg::in_item_t   in_data_i,
  // result words
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output tfsjc_pkg::out_item_t       out_data_o,
  // register port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [4:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import tfsjc_pkg::*;

  localparam int unsigned AW = ANGLE_WIDTH;
  localparam int unsigned TW = TIMER_WIDTH;
  localparam int unsigned CW = (TW > 16) ? TW : 16;
  localparam int unsigned MW = (AW > MAG_BITS) ? AW : MAG_BITS;

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  logic [14:0] friction_speed_q;
  logic [19:0] bullet_angle_q;
  logic [15:0] angle_tolerance_q;
  logic [15:0] pos_gain_q;
  logic [14:0] max_trigger_speed_q;
  logic [14:0] block_speed_q;
  logic [15:0] jam_ticks_q;
  logic [15:0] reverse_ticks_q;
  logic        cfg_write;
  logic [2:0]  cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[4:2];

  // write the selected register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      friction_speed_q    <= FRICTION_SPEED_RST;
      bullet_angle_q      <= BULLET_ANGLE_RST;
      angle_tolerance_q   <= ANGLE_TOLERANCE_RST;
      pos_gain_q          <= POS_GAIN_RST;
      max_trigger_speed_q <= MAX_TRIGGER_SPEED_RST;
      block_speed_q       <= BLOCK_SPEED_RST;
      jam_ticks_q         <= JAM_TICKS_RST;
      reverse_ticks_q     <= REVERSE_TICKS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRICTION_SPEED:    friction_speed_q    <= pwdata[14:0];
        REG_BULLET_ANGLE:      bullet_angle_q      <= pwdata[19:0];
        REG_ANGLE_TOLERANCE:   angle_tolerance_q   <= pwdata[15:0];
        REG_POS_GAIN:          pos_gain_q          <= pwdata[15:0];
        REG_MAX_TRIGGER_SPEED: max_trigger_speed_q <= pwdata[14:0];
        REG_BLOCK_SPEED:       block_speed_q       <= pwdata[14:0];
        REG_JAM_TICKS:         jam_ticks_q         <= pwdata[15:0];
        REG_REVERSE_TICKS:     reverse_ticks_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (cfg_index)
      REG_FRICTION_SPEED:    prdata = {17'd0, friction_speed_q};
      REG_BULLET_ANGLE:      prdata = {12'd0, bullet_angle_q};
      REG_ANGLE_TOLERANCE:   prdata = {16'd0, angle_tolerance_q};
      REG_POS_GAIN:          prdata = {16'd0, pos_gain_q};
      REG_MAX_TRIGGER_SPEED: prdata = {17'd0, max_trigger_speed_q};
      REG_BLOCK_SPEED:       prdata = {17'd0, block_speed_q};
      REG_JAM_TICKS:         prdata = {16'd0, jam_ticks_q};
      REG_REVERSE_TICKS:     prdata = {16'd0, reverse_ticks_q};
      default:               prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: A input, B state update, C multiply, D result
  // --------------------------------------------------------------------------
  logic a_valid_q, b_valid_q, c_valid_q, out_valid_q;
  logic d_ready, c_ready, b_ready, a_ready;
  logic adv_b, adv_c, adv_d;

  assign d_ready = !out_valid_q || out_ready_i;
  assign c_ready = !c_valid_q || d_ready;
  assign b_ready = !b_valid_q || c_ready;
  assign a_ready = !a_valid_q || b_ready;
  assign adv_b   = a_valid_q && b_ready;
  assign adv_c   = b_valid_q && c_ready;
  assign adv_d   = c_valid_q && d_ready;

  assign in_ready_o  = a_ready;
  assign out_valid_o = out_valid_q;

  // advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q   <= in_valid_i;
      if (b_ready) b_valid_q   <= a_valid_q;
      if (c_ready) c_valid_q   <= b_valid_q;
      if (d_ready) out_valid_q <= c_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: input register
  // --------------------------------------------------------------------------
  in_item_t a_q;

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_q <= in_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: unwrap angle, run the mode machine, pick the position error
  // --------------------------------------------------------------------------
  mode_e          mode_q, mode_d;
  logic           fire_seen_q, fire_seen_d;
  logic [14:0]    prev_angle_q, prev_angle_d;
  logic [AW-1:0]  total_q, total_d;
  logic [AW-1:0]  target_q, target_d;
  logic [TW-1:0]  stall_q, stall_d;
  logic [TW-1:0]  reverse_q, reverse_d;
  logic           tgt_step, tgt_sync;

  logic               sw_warm, sw_fire, sw_on;
  logic signed [16:0] delta_raw, delta;
  logic [AW-1:0]      total_tick;
  logic [AW-1:0]      err_raw, em_mag;
  logic               em_neg, em_lt_tol, em_gt_tol;
  logic signed [16:0] tspd_ext;
  logic [16:0]        tspd_abs;
  logic signed [17:0] dl, dr;
  logic [17:0]        dl_abs, dr_abs;
  logic               fric_ok, stalled;

  assign sw_warm = (a_q.switch_pos == SW_WARM);
  assign sw_fire = (a_q.switch_pos == SW_FIRE);
  assign sw_on   = sw_warm || sw_fire;

  // unwrap: shortest step between consecutive wrapped angles
  always_comb begin
    delta_raw = $signed({2'b00, a_q.raw_angle}) - $signed({2'b00, prev_angle_q});
    if (delta_raw < -HALF_TURN) begin
      delta = delta_raw + FULL_TURN;
    end else if (delta_raw > HALF_TURN) begin
      delta = delta_raw - FULL_TURN;
    end else begin
      delta = delta_raw;
    end
  end

  assign total_tick = total_q + {{(AW-17){delta[16]}}, delta};

  // error against the held target, as sign and magnitude
  assign err_raw   = target_q - total_tick;
  assign em_neg    = err_raw[AW-1];
  assign em_mag    = em_neg ? (~err_raw + 1'b1) : err_raw;
  assign em_lt_tol = em_mag < AW'(angle_tolerance_q);
  assign em_gt_tol = em_mag > AW'(angle_tolerance_q);

  // stall detect on trigger speed
  assign tspd_ext = 17'(a_q.trigger_speed);
  assign tspd_abs = tspd_ext[16] ? 17'(-tspd_ext) : 17'(tspd_ext);
  assign stalled  = em_gt_tol && (tspd_abs < {2'b00, block_speed_q});

  // friction wheels at speed
  assign dl      = 18'(a_q.left_speed) - $signed({3'b000, friction_speed_q});
  assign dr      = 18'(a_q.right_speed) + $signed({3'b000, friction_speed_q});
  assign dl_abs  = dl[17] ? 18'(-dl) : 18'(dl);
  assign dr_abs  = dr[17] ? 18'(-dr) : 18'(dr);
  assign fric_ok = (dl_abs < FRICTION_WINDOW) && (dr_abs < FRICTION_WINDOW);

  // next state
  always_comb begin
    mode_d       = mode_q;
    fire_seen_d  = fire_seen_q;
    prev_angle_d = prev_angle_q;
    total_d      = total_q;
    target_d     = target_q;
    stall_d      = stall_q;
    reverse_d    = reverse_q;
    tgt_step     = 1'b0;
    tgt_sync     = 1'b0;
    if (a_q.op == OP_INIT) begin
      prev_angle_d = a_q.raw_angle;
      total_d      = AW'(a_q.raw_angle);
      target_d     = AW'(a_q.raw_angle);
    end else begin
      prev_angle_d = a_q.raw_angle;
      total_d      = total_tick;
      fire_seen_d  = sw_fire;
      case (mode_q)
        MODE_STOP: begin
          stall_d = '0;
          if (sw_warm) mode_d = MODE_PREP;
        end
        MODE_PREP: begin
          if (fric_ok) begin
            mode_d = MODE_READY;
          end else if (!sw_warm) begin
            mode_d = MODE_STOP;
          end
        end
        MODE_READY: begin
          stall_d = '0;
          if (sw_fire && !fire_seen_q) begin
            mode_d   = MODE_SHOOT;
            target_d = total_tick + AW'(bullet_angle_q);
            tgt_step = 1'b1;
          end else if (!sw_on) begin
            mode_d = MODE_STOP;
          end
        end
        MODE_SHOOT: begin
          if (em_lt_tol) mode_d = MODE_READY;
          if (stalled) begin
            stall_d = (&stall_q) ? stall_q : stall_q + 1'b1;
          end else begin
            stall_d = '0;
          end
          if (CW'(stall_d) > CW'(jam_ticks_q)) begin
            mode_d    = MODE_JAM;
            reverse_d = '0;
          end
          if (!sw_on) mode_d = MODE_STOP;
        end
        MODE_JAM: begin
          reverse_d = (&reverse_q) ? reverse_q : reverse_q + 1'b1;
          if (CW'(reverse_d) > CW'(reverse_ticks_q)) begin
            mode_d   = MODE_READY;
            target_d = total_tick;
            tgt_sync = 1'b1;
          end
          if (!sw_on) mode_d = MODE_STOP;
        end
        default: begin
          mode_d = MODE_STOP;
        end
      endcase
    end
  end

  // error seen by the P path after this word, capped to the multiplier width
  logic [AW-1:0]       out_mag;
  logic                out_neg;
  logic [MW-1:0]       out_mag_ext;
  logic [MAG_BITS-1:0] out_mag_cap;

  always_comb begin
    if ((a_q.op == OP_INIT) || tgt_sync) begin
      out_mag = '0;
      out_neg = 1'b0;
    end else if (tgt_step) begin
      out_mag = AW'(bullet_angle_q);
      out_neg = 1'b0;
    end else begin
      out_mag = em_mag;
      out_neg = em_neg;
    end
    out_mag_ext = MW'(out_mag);
    if (|out_mag_ext[MW-1:MAG_BITS-1]) begin
      out_mag_cap = {1'b1, {(MAG_BITS-1){1'b0}}};
    end else begin
      out_mag_cap = out_mag_ext[MAG_BITS-1:0];
    end
  end

  // hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_STOP;
      fire_seen_q  <= 1'b0;
      prev_angle_q <= '0;
      total_q      <= '0;
      target_q     <= '0;
      stall_q      <= '0;
      reverse_q    <= '0;
    end else if (adv_b) begin
      mode_q       <= mode_d;
      fire_seen_q  <= fire_seen_d;
      prev_angle_q <= prev_angle_d;
      total_q      <= total_d;
      target_q     <= target_d;
      stall_q      <= stall_d;
      reverse_q    <= reverse_d;
    end
  end

  logic                b_neg_q;
  logic [MAG_BITS-1:0] b_mag_q;
  mode_e               b_mode_q;

  always_ff @(posedge clk_i) begin
    if (adv_b) begin
      b_neg_q  <= out_neg;
      b_mag_q  <= out_mag_cap;
      b_mode_q <= mode_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: error times gain
  // --------------------------------------------------------------------------
  logic                 c_neg_q;
  logic [PROD_BITS-1:0] c_prod_q;
  mode_e                c_mode_q;

  always_ff @(posedge clk_i) begin
    if (adv_c) begin
      c_neg_q  <= b_neg_q;
      c_prod_q <= PROD_BITS'(b_mag_q) * PROD_BITS'(pos_gain_q);
      c_mode_q <= b_mode_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: floor shift, clamp per mode, build the result word
  // --------------------------------------------------------------------------
  localparam int unsigned QW = PROD_BITS - GAIN_SHIFT;

  logic [QW-1:0]      q_trunc, q_round;
  logic [16:0]        q_cap, lim, q_lim;
  logic signed [15:0] trig_cmd;
  logic [14:0]        left_cmd;
  out_item_t          out_d, out_q;

  // floor toward minus infinity for negative errors
  assign q_trunc = c_prod_q[PROD_BITS-1:GAIN_SHIFT];
  assign q_round = q_trunc + QW'(c_neg_q && (|c_prod_q[GAIN_SHIFT-1:0]));
  assign q_cap   = (q_round > QW'(PCMD_CAP)) ? PCMD_CAP : q_round[16:0];
  assign lim     = {2'b00, max_trigger_speed_q};
  assign q_lim   = (q_cap > lim) ? lim : q_cap;

  always_comb begin
    case (c_mode_q)
      MODE_PREP: begin
        if (!c_neg_q) begin
          trig_cmd = (q_cap > 17'd32767) ? 16'sd32767 : $signed(q_cap[15:0]);
        end else begin
          trig_cmd = (q_cap > 17'd32768) ? -16'sd32768 : $signed(16'(-q_cap));
        end
      end
      MODE_READY, MODE_SHOOT: begin
        trig_cmd = c_neg_q ? $signed(16'(-q_lim)) : $signed(q_lim[15:0]);
      end
      MODE_JAM: begin
        trig_cmd = JAM_TRIGGER_CMD;
      end
      default: begin
        trig_cmd = 16'sd0;
      end
    endcase
  end

  assign left_cmd = (c_mode_q == MODE_STOP) ? 15'd0 : friction_speed_q;

  always_comb begin
    out_d.left_cmd    = left_cmd;
    out_d.right_cmd   = $signed(16'(-{1'b0, left_cmd}));
    out_d.trigger_cmd = trig_cmd;
    out_d.mode        = c_mode_q;
  end

  // load the result register
  always_ff @(posedge clk_i) begin
    if (adv_d) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire
